### src/pcmd_pkg.sv
// Shared codes, constants and types of the PCM DSP command port.
package pcmd_pkg;

  // Access kinds carried on the input channel
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_BLOCK = 2'd2;

  // Port offsets from the card base
  localparam logic [3:0] PORT_MIX_IDX = 4'd4;
  localparam logic [3:0] PORT_MIX_DAT = 4'd5;
  localparam logic [3:0] PORT_RESET   = 4'd6;
  localparam logic [3:0] PORT_READ    = 4'd10;
  localparam logic [3:0] PORT_CMD     = 4'd12;
  localparam logic [3:0] PORT_STATUS  = 4'd14;
  localparam logic [3:0] PORT_ACK16   = 4'd15;

  // DSP opcodes
  localparam logic [7:0] OP_RATE_OUT = 8'h41;
  localparam logic [7:0] OP_RATE_IN  = 8'h42;
  localparam logic [7:0] OP_PAUSE_A  = 8'hD0;
  localparam logic [7:0] OP_PAUSE_B  = 8'hD5;
  localparam logic [7:0] OP_CONT_A   = 8'hD4;
  localparam logic [7:0] OP_CONT_B   = 8'hD6;
  localparam logic [7:0] OP_SPK_ON   = 8'hD1;
  localparam logic [7:0] OP_SPK_OFF  = 8'hD3;
  localparam logic [7:0] OP_EXIT_A   = 8'hD9;
  localparam logic [7:0] OP_EXIT_B   = 8'hDA;
  localparam logic [7:0] OP_VERSION  = 8'hE1;
  localparam logic [3:0] FAM_WIDE    = 4'hB;
  localparam logic [3:0] FAM_NARROW  = 4'hC;

  // Fixed values
  localparam logic [7:0]  RESET_ACK   = 8'hAA;
  localparam logic [7:0]  STAT_READY  = 8'h80;
  localparam logic [7:0]  MIX_IRQ_IDX = 8'h82;
  localparam logic [15:0] VERSION_RST = 16'd1029;
  localparam int          MIX_REGS    = 256;

  // Mixer store request from the decode logic
  typedef struct packed {
    logic       idx_wr;  // load the mixer index
    logic       dat_wr;  // write the entry at the current index
    logic [7:0] wdata;
  } mix_req_t;

endpackage

### src/pcmd_mixer.sv
// Mixer index register and 256-entry mixer store with per-entry valid bits.
module pcmd_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  pcmd_pkg::mix_req_t req,
  output logic [7:0]         mix_idx,
  output logic [7:0]         mix_val
);
  import pcmd_pkg::*;

  logic [7:0]          idx_r;
  logic [7:0]          idx_nxt;
  logic [7:0]          mem [MIX_REGS];
  logic [MIX_REGS-1:0] vld_r;
  logic [7:0]          mem_q_r;
  logic                vld_q_r;
  logic                byp_r;
  logic [7:0]          byp_d_r;

  // Index follows port writes; the store is read ahead at the next index
  assign idx_nxt = req.idx_wr ? req.wdata : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      vld_r   <= '0;
      vld_q_r <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      if (req.dat_wr) begin
        vld_r[idx_r] <= 1'b1;
      end
      vld_q_r <= vld_r[idx_nxt];
      byp_r   <= req.dat_wr;
    end
  end

  // Store array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.dat_wr) begin
      mem[idx_r] <= req.wdata;
    end
    mem_q_r <= mem[idx_nxt];
    byp_d_r <= req.wdata;
  end

  // A write in the previous cycle is not yet in the read register
  assign mix_idx = idx_r;
  assign mix_val = byp_r ? byp_d_r : (vld_q_r ? mem_q_r : 8'h00);

endmodule

### src/pcm_audio_dsp_command_port.sv
// Top level of the PCM DSP command port: decode, command parser and result register.
// Each accepted beat is one host port access or one DMA block-end event and yields
// exactly one result beat in the following cycle, taken from the state after that access.
// One beat is accepted per cycle; the only limit is the result register, which
// takes a new beat whenever it is empty or being drained in the same cycle. There
// is no start-up sweep: the mixer store reads as zero through per-entry valid bits
// from the first cycle after reset. The version word is written through the cfg
// channel, which is always ready, and should be written only while the block idles.
module pcm_audio_dsp_command_port #(
  parameter int REPLY_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_version_word,
  // access channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_port_offset,
  input  logic [7:0]  in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_irq_pending,
  output logic        out_transfer_active,
  output logic        out_transfer_paused,
  output logic        out_speaker_enabled,
  output logic [15:0] out_sample_rate,
  output logic        out_wide_samples,
  output logic        out_stereo_mode,
  output logic        out_signed_mode,
  output logic        out_auto_repeat,
  output logic [15:0] out_block_count
);
  import pcmd_pkg::*;

  localparam int              CW    = $clog2(REPLY_DEPTH + 1);
  localparam logic [CW-1:0]   DEPTH = CW'(REPLY_DEPTH);

  // State
  logic [15:0]  version_r;
  logic         latch_r,  latch_nxt;
  logic [7:0]   q_r [REPLY_DEPTH];
  logic [7:0]   q_nxt [REPLY_DEPTH];
  logic [CW-1:0] cnt_r,   cnt_nxt;
  logic [7:0]   op_r,     op_nxt;
  logic [1:0]   ops_r,    ops_nxt;
  logic [15:0]  hold_r,   hold_nxt;
  logic [1:0]   irq_r,    irq_nxt;
  logic         act_r,    act_nxt;
  logic         pau_r,    pau_nxt;
  logic         spk_r,    spk_nxt;
  logic         wide_r,   wide_nxt;
  logic         ster_r,   ster_nxt;
  logic         sgn_r,    sgn_nxt;
  logic         auto_r,   auto_nxt;
  logic [15:0]  rate_r,   rate_nxt;
  logic [15:0]  count_r,  count_nxt;
  logic [7:0]   rd;

  // Output register
  logic         out_valid_r;
  logic [7:0]   o_rd_r;
  logic         o_irq_r, o_act_r, o_pau_r, o_spk_r, o_wide_r, o_ster_r, o_sgn_r, o_auto_r;
  logic [15:0]  o_rate_r, o_count_r;

  logic         acc;
  logic         restart;
  logic         pop;
  logic         ver_push;
  mix_req_t     mix_req;
  logic [7:0]   mix_idx;
  logic [7:0]   mix_val;

  assign acc       = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  pcmd_mixer u_mixer (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mix_req),
    .mix_idx (mix_idx),
    .mix_val (mix_val)
  );

  // Access decode and command parser
  always_comb begin
    latch_nxt = latch_r;
    op_nxt    = op_r;
    ops_nxt   = ops_r;
    hold_nxt  = hold_r;
    irq_nxt   = irq_r;
    act_nxt   = act_r;
    pau_nxt   = pau_r;
    spk_nxt   = spk_r;
    wide_nxt  = wide_r;
    ster_nxt  = ster_r;
    sgn_nxt   = sgn_r;
    auto_nxt  = auto_r;
    rate_nxt  = rate_r;
    count_nxt = count_r;
    rd        = 8'h00;
    restart   = 1'b0;
    pop       = 1'b0;
    ver_push  = 1'b0;
    mix_req   = '{idx_wr: 1'b0, dat_wr: 1'b0, wdata: in_write_data};

    if (acc) begin
      case (in_command)
        CMD_READ: begin
          case (in_port_offset)
            PORT_MIX_IDX: rd = mix_idx;
            PORT_MIX_DAT: rd = (mix_idx == MIX_IRQ_IDX) ? {6'b0, irq_r} : mix_val;
            PORT_READ: begin
              if (cnt_r != '0) begin
                rd  = q_r[0];
                pop = 1'b1;
              end
            end
            PORT_STATUS: begin
              rd         = (cnt_r != '0) ? STAT_READY : 8'h00;
              irq_nxt[0] = 1'b0;
            end
            PORT_ACK16: irq_nxt[1] = 1'b0;
            default: ;
          endcase
        end
        CMD_WRITE: begin
          case (in_port_offset)
            PORT_MIX_IDX: mix_req.idx_wr = 1'b1;
            PORT_MIX_DAT: mix_req.dat_wr = (mix_idx != MIX_IRQ_IDX);
            PORT_RESET: begin
              if (in_write_data[0]) begin
                latch_nxt = 1'b1;
              end else if (latch_r) begin
                latch_nxt = 1'b0;
                restart   = 1'b1;
              end
            end
            PORT_CMD: begin
              if (ops_r != 2'd0) begin
                // operand bytes of a pending opcode
                if (op_r == OP_RATE_OUT || op_r == OP_RATE_IN) begin
                  if (ops_r == 2'd2) begin
                    hold_nxt = {in_write_data, 8'h00};
                    ops_nxt  = 2'd1;
                  end else begin
                    rate_nxt = hold_r | {8'h00, in_write_data};
                    ops_nxt  = 2'd0;
                  end
                end else if (ops_r == 2'd3) begin
                  hold_nxt = {8'h00, in_write_data};
                  ops_nxt  = 2'd2;
                end else if (ops_r == 2'd2) begin
                  hold_nxt = {in_write_data, hold_r[7:0]};
                  ops_nxt  = 2'd1;
                end else begin
                  // count high byte: transfer starts
                  count_nxt = {in_write_data, hold_r[15:8]};
                  act_nxt   = 1'b1;
                  pau_nxt   = 1'b0;
                  wide_nxt  = (op_r[7:4] == FAM_WIDE);
                  ster_nxt  = hold_r[5];
                  sgn_nxt   = hold_r[4];
                  auto_nxt  = op_r[2];
                  ops_nxt   = 2'd0;
                end
              end else if (in_write_data == OP_RATE_OUT || in_write_data == OP_RATE_IN) begin
                op_nxt  = in_write_data;
                ops_nxt = 2'd2;
              end else if (in_write_data[7:4] == FAM_WIDE ||
                           in_write_data[7:4] == FAM_NARROW) begin
                op_nxt  = in_write_data;
                ops_nxt = 2'd3;
              end else if (in_write_data == OP_PAUSE_A || in_write_data == OP_PAUSE_B) begin
                if (act_r) pau_nxt = 1'b1;
              end else if (in_write_data == OP_CONT_A || in_write_data == OP_CONT_B) begin
                pau_nxt = 1'b0;
              end else if (in_write_data == OP_SPK_ON) begin
                spk_nxt = 1'b1;
              end else if (in_write_data == OP_SPK_OFF) begin
                spk_nxt = 1'b0;
              end else if (in_write_data == OP_EXIT_A || in_write_data == OP_EXIT_B) begin
                auto_nxt = 1'b0;
              end else if (in_write_data == OP_VERSION) begin
                ver_push = 1'b1;
              end
            end
            default: ;
          endcase
        end
        CMD_BLOCK: begin
          if (act_r && !pau_r) begin
            if (wide_r) irq_nxt[1] = 1'b1;
            else        irq_nxt[0] = 1'b1;
            if (!auto_r) act_nxt = 1'b0;
          end
        end
        default: ;
      endcase

      // DSP restart clears everything but the latch, the version word and the mixer
      if (restart) begin
        op_nxt    = 8'h00;
        ops_nxt   = 2'd0;
        hold_nxt  = 16'h0000;
        irq_nxt   = 2'b00;
        act_nxt   = 1'b0;
        pau_nxt   = 1'b0;
        spk_nxt   = 1'b0;
        wide_nxt  = 1'b0;
        ster_nxt  = 1'b0;
        sgn_nxt   = 1'b0;
        auto_nxt  = 1'b0;
        rate_nxt  = 16'h0000;
        count_nxt = 16'h0000;
      end
    end
  end

  // Reply queue: shift out at the head, push one or two bytes at the tail
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (restart) begin
      q_nxt[0] = RESET_ACK;
      cnt_nxt  = CW'(1);
    end else if (pop) begin
      for (int i = 0; i < REPLY_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_r - CW'(1);
    end else if (ver_push) begin
      for (int i = 0; i < REPLY_DEPTH; i++) begin
        if (cnt_r == CW'(i)) q_nxt[i] = version_r[15:8];
        if (i > 0 && cnt_r == CW'(i - 1)) q_nxt[i] = version_r[7:0];
      end
      if (cnt_r < DEPTH - CW'(1)) cnt_nxt = cnt_r + CW'(2);
      else                        cnt_nxt = DEPTH;
    end
  end

  // Control and DSP state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_RST;
      latch_r   <= 1'b0;
      cnt_r     <= '0;
      op_r      <= '0;
      ops_r     <= '0;
      hold_r    <= '0;
      irq_r     <= '0;
      act_r     <= 1'b0;
      pau_r     <= 1'b0;
      spk_r     <= 1'b0;
      wide_r    <= 1'b0;
      ster_r    <= 1'b0;
      sgn_r     <= 1'b0;
      auto_r    <= 1'b0;
      rate_r    <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) version_r <= cfg_version_word;
      latch_r <= latch_nxt;
      cnt_r   <= cnt_nxt;
      op_r    <= op_nxt;
      ops_r   <= ops_nxt;
      hold_r  <= hold_nxt;
      irq_r   <= irq_nxt;
      act_r   <= act_nxt;
      pau_r   <= pau_nxt;
      spk_r   <= spk_nxt;
      wide_r  <= wide_nxt;
      ster_r  <= ster_nxt;
      sgn_r   <= sgn_nxt;
      auto_r  <= auto_nxt;
      rate_r  <= rate_nxt;
      count_r <= count_nxt;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: post-update state of the accepted beat
  always_ff @(posedge clk) begin
    if (acc) begin
      o_rd_r    <= rd;
      o_irq_r   <= |irq_nxt;
      o_act_r   <= act_nxt;
      o_pau_r   <= pau_nxt;
      o_spk_r   <= spk_nxt;
      o_rate_r  <= rate_nxt;
      o_wide_r  <= wide_nxt;
      o_ster_r  <= ster_nxt;
      o_sgn_r   <= sgn_nxt;
      o_auto_r  <= auto_nxt;
      o_count_r <= count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_read_data       = o_rd_r;
  assign out_irq_pending     = o_irq_r;
  assign out_transfer_active = o_act_r;
  assign out_transfer_paused = o_pau_r;
  assign out_speaker_enabled = o_spk_r;
  assign out_sample_rate     = o_rate_r;
  assign out_wide_samples    = o_wide_r;
  assign out_stereo_mode     = o_ster_r;
  assign out_signed_mode     = o_sgn_r;
  assign out_auto_repeat     = o_auto_r;
  assign out_block_count     = o_count_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH) else $error("reply count beyond queue depth");

  a_pause_active: assert property (@(posedge clk) disable iff (!rst_n)
    pau_r |-> act_r) else $error("paused without a running transfer");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid) else $error("accepted beat produced no result");

  a_three_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (ops_r == 2'd3) |-> (op_r[7:4] == FAM_WIDE || op_r[7:4] == FAM_NARROW))
    else $error("three operands pending for a non-transfer opcode");

endmodule

### tb/pcm_audio_dsp_command_port_tb.sv
// Self-checking testbench for the PCM DSP command port: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module pcm_audio_dsp_command_port_tb;
  import pcmd_pkg::*;

  localparam int unsigned REPLY_SLOTS = 4;
  localparam int unsigned DIR_ROWS = 30;
  localparam int unsigned PHASE_BEATS = 300;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // one host access as offered on the input channel
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] port;
    logic [7:0] data;
  } access_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_pending;
    logic        xfer_active;
    logic        xfer_paused;
    logic        speaker_on;
    logic [15:0] rate;
    logic        wide;
    logic        stereo;
    logic        signed_md;
    logic        auto_rep;
    logic [15:0] count;
  } dsp_result_t;

  // directed row: access plus an optional hand-typed read byte
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] port;
    logic [7:0] data;
    bit         typed;
    logic [7:0] rd;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_version_word = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = 2'd0;
  logic [3:0]  in_port_offset = 4'd0;
  logic [7:0]  in_write_data = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_irq_pending;
  logic        out_transfer_active;
  logic        out_transfer_paused;
  logic        out_speaker_enabled;
  logic [15:0] out_sample_rate;
  logic        out_wide_samples;
  logic        out_stereo_mode;
  logic        out_signed_mode;
  logic        out_auto_repeat;
  logic [15:0] out_block_count;

  pcm_audio_dsp_command_port #(.REPLY_DEPTH(REPLY_SLOTS)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_version_word    (cfg_version_word),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_port_offset      (in_port_offset),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_irq_pending     (out_irq_pending),
    .out_transfer_active (out_transfer_active),
    .out_transfer_paused (out_transfer_paused),
    .out_speaker_enabled (out_speaker_enabled),
    .out_sample_rate     (out_sample_rate),
    .out_wide_samples    (out_wide_samples),
    .out_stereo_mode     (out_stereo_mode),
    .out_signed_mode     (out_signed_mode),
    .out_auto_repeat     (out_auto_repeat),
    .out_block_count     (out_block_count)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted DSP state
  logic [15:0] ver_word;
  logic        dsp_latch;
  logic [7:0]  reply_q [$];
  logic [7:0]  pend_op;
  logic [1:0]  ops_left;
  logic [15:0] op_hold;
  logic [7:0]  mix_idx;
  logic [7:0]  mix_mem [0:MIX_REGS-1];
  logic [1:0]  irq_flags;  // bit 0 8-bit block, bit 1 16-bit block
  logic        xfer_on, xfer_hold, spk_on, xfer_wide, xfer_stereo, xfer_signed, xfer_auto;
  logic [15:0] rate_reg;
  logic [15:0] count_reg;

  dsp_result_t results_due [$];
  access_t     stim_q [$];
  bit          fault_seen = 1'b0;

  function automatic void queue_reply(input logic [7:0] b);
    if (reply_q.size() < REPLY_SLOTS) reply_q.push_back(b);
  endfunction

  function automatic logic [7:0] take_reply();
    if (reply_q.size() == 0) return 8'h00;
    return reply_q.pop_front();
  endfunction

  // DSP reset through the latch: mixer is kept, 0xAA is queued
  function automatic void restart_dsp();
    reply_q.delete();
    pend_op = 8'h00;
    ops_left = 2'd0;
    op_hold = 16'h0000;
    irq_flags = 2'b00;
    {xfer_on, xfer_hold, spk_on, xfer_wide, xfer_stereo, xfer_signed, xfer_auto} = 7'd0;
    rate_reg = 16'h0000;
    count_reg = 16'h0000;
    queue_reply(RESET_ACK);
  endfunction

  // command port byte: opcode or operand of a pending opcode
  function automatic void parse_cmd_byte(input logic [7:0] d);
    if (ops_left != 2'd0) begin
      if (pend_op == OP_RATE_OUT || pend_op == OP_RATE_IN) begin
        if (ops_left == 2'd2) begin
          op_hold = {d, 8'h00};
          ops_left = 2'd1;
        end else begin
          rate_reg = op_hold | {8'h00, d};
          ops_left = 2'd0;
        end
      end else if (ops_left == 2'd3) begin
        op_hold = {8'h00, d};
        ops_left = 2'd2;
      end else if (ops_left == 2'd2) begin
        op_hold = {d, op_hold[7:0]};
        ops_left = 2'd1;
      end else begin
        // count high byte: transfer starts, speaker state kept
        count_reg = {d, op_hold[15:8]};
        xfer_on = 1'b1;
        xfer_hold = 1'b0;
        xfer_wide = (pend_op[7:4] == FAM_WIDE);
        xfer_stereo = op_hold[5];
        xfer_signed = op_hold[4];
        xfer_auto = pend_op[2];
        ops_left = 2'd0;
      end
    end else if (d == OP_RATE_OUT || d == OP_RATE_IN) begin
      pend_op = d;
      ops_left = 2'd2;
    end else if (d[7:4] == FAM_WIDE || d[7:4] == FAM_NARROW) begin
      pend_op = d;
      ops_left = 2'd3;
    end else if (d == OP_PAUSE_A || d == OP_PAUSE_B) begin
      if (xfer_on) xfer_hold = 1'b1;
    end else if (d == OP_CONT_A || d == OP_CONT_B) begin
      xfer_hold = 1'b0;
    end else if (d == OP_SPK_ON) begin
      spk_on = 1'b1;
    end else if (d == OP_SPK_OFF) begin
      spk_on = 1'b0;
    end else if (d == OP_EXIT_A || d == OP_EXIT_B) begin
      xfer_auto = 1'b0;
    end else if (d == OP_VERSION) begin
      queue_reply(ver_word[15:8]);
      queue_reply(ver_word[7:0]);
    end
  endfunction

  // apply one access to the predicted state and return the result beat
  function automatic dsp_result_t apply_access(input access_t a);
    dsp_result_t r;
    logic [7:0]  rd;
    rd = 8'h00;
    case (a.cmd)
      CMD_READ: begin
        case (a.port)
          PORT_MIX_IDX: rd = mix_idx;
          PORT_MIX_DAT: rd = (mix_idx == MIX_IRQ_IDX) ? {6'd0, irq_flags} : mix_mem[mix_idx];
          PORT_READ:    rd = take_reply();
          PORT_STATUS: begin
            rd = (reply_q.size() != 0) ? STAT_READY : 8'h00;
            irq_flags[0] = 1'b0;
          end
          PORT_ACK16:   irq_flags[1] = 1'b0;
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (a.port)
          PORT_MIX_IDX: mix_idx = a.data;
          PORT_MIX_DAT: if (mix_idx != MIX_IRQ_IDX) mix_mem[mix_idx] = a.data;
          PORT_RESET: begin
            if (a.data[0]) begin
              dsp_latch = 1'b1;
            end else if (dsp_latch) begin
              dsp_latch = 1'b0;
              restart_dsp();
            end
          end
          PORT_CMD: parse_cmd_byte(a.data);
          default: ;
        endcase
      end
      CMD_BLOCK: begin
        if (xfer_on && !xfer_hold) begin
          if (xfer_wide) irq_flags[1] = 1'b1;
          else irq_flags[0] = 1'b1;
          if (!xfer_auto) xfer_on = 1'b0;
        end
      end
      default: ;
    endcase
    r.read_data = rd;
    r.irq_pending = |irq_flags;
    r.xfer_active = xfer_on;
    r.xfer_paused = xfer_hold;
    r.speaker_on = spk_on;
    r.rate = rate_reg;
    r.wide = xfer_wide;
    r.stereo = xfer_stereo;
    r.signed_md = xfer_signed;
    r.auto_rep = xfer_auto;
    r.count = count_reg;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void plan_access(input logic [1:0] c, input logic [3:0] p,
                                      input logic [7:0] d);
    access_t a;
    a.cmd = c;
    a.port = p;
    a.data = d;
    stim_q.push_back(a);
  endfunction

  // queue one random sequence, mostly well-formed command sequences
  function automatic void plan_sequence();
    logic [7:0]  op;
    logic [3:0]  p;
    int unsigned pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 14) begin
      // rate: opcode, high, low
      plan_access(CMD_WRITE, PORT_CMD, $urandom_range(0, 1) ? OP_RATE_OUT : OP_RATE_IN);
      plan_access(CMD_WRITE, PORT_CMD, rand_byte());
      plan_access(CMD_WRITE, PORT_CMD, rand_byte());
    end else if (pick < 30) begin
      // transfer start: opcode, mode, count low, count high
      op = {$urandom_range(0, 1) ? FAM_WIDE : FAM_NARROW, 4'($urandom_range(0, 15))};
      plan_access(CMD_WRITE, PORT_CMD, op);
      plan_access(CMD_WRITE, PORT_CMD, rand_byte());
      if ($urandom_range(0, 7) == 0) plan_access(CMD_READ, PORT_STATUS, rand_byte());
      plan_access(CMD_WRITE, PORT_CMD, rand_byte());
      plan_access(CMD_WRITE, PORT_CMD, rand_byte());
    end else if (pick < 46) begin
      // single-byte control commands
      case ($urandom_range(0, 9))
        0: op = OP_PAUSE_A;
        1: op = OP_PAUSE_B;
        2: op = OP_CONT_A;
        3: op = OP_CONT_B;
        4: op = OP_SPK_ON;
        5: op = OP_SPK_OFF;
        6: op = OP_EXIT_A;
        7: op = OP_EXIT_B;
        8: op = OP_VERSION;
        default: op = rand_byte();
      endcase
      plan_access(CMD_WRITE, PORT_CMD, op);
    end else if (pick < 60) begin
      n = xfer_on ? $urandom_range(1, 3) : 1;
      repeat (n) plan_access(CMD_BLOCK, 4'($urandom_range(0, 15)), rand_byte());
    end else if (pick < 74) begin
      case ($urandom_range(0, 4))
        0: p = PORT_READ;
        1: p = PORT_STATUS;
        2: p = PORT_ACK16;
        3: p = PORT_MIX_DAT;
        default: p = PORT_MIX_IDX;
      endcase
      plan_access(CMD_READ, p, rand_byte());
    end else if (pick < 82) begin
      // mixer entry write and read back
      plan_access(CMD_WRITE, PORT_MIX_IDX,
                  ($urandom_range(0, 7) == 0) ? MIX_IRQ_IDX : rand_byte());
      plan_access(CMD_WRITE, PORT_MIX_DAT, rand_byte());
      plan_access(CMD_READ, PORT_MIX_DAT, rand_byte());
    end else if (pick < 86) begin
      // reset latch: arm then release
      plan_access(CMD_WRITE, PORT_RESET, rand_byte() | 8'h01);
      plan_access(CMD_WRITE, PORT_RESET, rand_byte() & 8'hFE);
    end else if (pick < 90) begin
      plan_access(CMD_WRITE, PORT_CMD, OP_VERSION);
      plan_access(CMD_READ, PORT_READ, rand_byte());
      plan_access(CMD_READ, PORT_READ, rand_byte());
    end else begin
      // noise: any access, including the unused command code
      plan_access(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), rand_byte());
    end
  endfunction

  // directed rows; rd is typed only where it is obvious
  function automatic dir_row_t dir_stim(input int unsigned i);
    dir_row_t r;
    r = '{CMD_NONE, 4'hF, 8'hFF, 1'b0, 8'h00};
    case (i)
      0:  r = '{CMD_READ,  PORT_READ,    8'h00,       1'b1, 8'h00}; // empty reply queue
      1:  r = '{CMD_WRITE, PORT_RESET,   8'h00,       1'b0, 8'h00}; // release, not armed
      2:  r = '{CMD_READ,  PORT_STATUS,  8'h00,       1'b1, 8'h00};
      3:  r = '{CMD_WRITE, PORT_MIX_IDX, 8'hFF,       1'b0, 8'h00};
      4:  r = '{CMD_WRITE, PORT_MIX_DAT, 8'hFF,       1'b0, 8'h00};
      5:  r = '{CMD_READ,  PORT_MIX_DAT, 8'h00,       1'b1, 8'hFF};
      6:  r = '{CMD_WRITE, PORT_MIX_IDX, MIX_IRQ_IDX, 1'b0, 8'h00};
      7:  r = '{CMD_WRITE, PORT_MIX_DAT, 8'hFF,       1'b0, 8'h00}; // status index, ignored
      8:  r = '{CMD_READ,  PORT_MIX_IDX, 8'h00,       1'b1, MIX_IRQ_IDX};
      9:  r = '{CMD_WRITE, PORT_RESET,   8'hFF,       1'b0, 8'h00}; // arm
      10: r = '{CMD_WRITE, PORT_RESET,   8'hFE,       1'b0, 8'h00}; // restart
      11: r = '{CMD_READ,  PORT_STATUS,  8'h00,       1'b1, STAT_READY};
      12: r = '{CMD_WRITE, PORT_CMD,     OP_VERSION,  1'b0, 8'h00};
      13: r = '{CMD_WRITE, PORT_CMD,     OP_VERSION,  1'b0, 8'h00}; // queue fills, low byte dropped
      14: r = '{CMD_READ,  PORT_READ,    8'h00,       1'b1, RESET_ACK};
      15: r = '{CMD_READ,  PORT_READ,    8'h00,       1'b1, VERSION_RST[15:8]};
      16: r = '{CMD_READ,  PORT_READ,    8'h00,       1'b1, VERSION_RST[7:0]};
      17: r = '{CMD_READ,  PORT_READ,    8'h00,       1'b1, VERSION_RST[15:8]};
      18: r = '{CMD_READ,  PORT_READ,    8'h00,       1'b1, 8'h00};
      19: r = '{CMD_WRITE, PORT_CMD,     {FAM_WIDE, 4'hF}, 1'b0, 8'h00}; // 16-bit, auto
      20: r = '{CMD_WRITE, PORT_CMD,     8'hFF,       1'b0, 8'h00};
      21: r = '{CMD_WRITE, PORT_CMD,     8'hFF,       1'b0, 8'h00};
      22: r = '{CMD_WRITE, PORT_CMD,     8'hFF,       1'b0, 8'h00};
      23: r = '{CMD_WRITE, PORT_CMD,     OP_PAUSE_A,  1'b0, 8'h00};
      24: r = '{CMD_BLOCK, 4'h0,         8'h00,       1'b0, 8'h00}; // paused, no effect
      25: r = '{CMD_WRITE, PORT_CMD,     OP_CONT_A,   1'b0, 8'h00};
      26: r = '{CMD_BLOCK, 4'hF,         8'hFF,       1'b0, 8'h00};
      27: r = '{CMD_READ,  PORT_MIX_DAT, 8'h00,       1'b1, 8'h02};
      28: r = '{CMD_READ,  PORT_ACK16,   8'h00,       1'b1, 8'h00};
      default: ;
    endcase
    return r;
  endfunction

  // offer one beat, wait for acceptance, record the expected result
  task automatic send_access(input access_t a, input int unsigned gap,
                             input bit typed, input logic [7:0] typed_rd);
    dsp_result_t r;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= a.cmd;
    in_port_offset <= a.port;
    in_write_data <= a.data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_access(a);
    if (typed) r.read_data = typed_rd;
    results_due.push_back(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_version(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_version_word <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ver_word = v;
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      fault_seen = 1'b1;
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    dsp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with nothing expected, read_data %0h", $time,
                 out_read_data);
        fault_seen = 1'b1;
      end else begin
        want = results_due.pop_front();
        check_field("read_data", 16'(want.read_data), 16'(out_read_data));
        check_field("irq_pending", 16'(want.irq_pending), 16'(out_irq_pending));
        check_field("transfer_active", 16'(want.xfer_active), 16'(out_transfer_active));
        check_field("transfer_paused", 16'(want.xfer_paused), 16'(out_transfer_paused));
        check_field("speaker_enabled", 16'(want.speaker_on), 16'(out_speaker_enabled));
        check_field("sample_rate", want.rate, out_sample_rate);
        check_field("wide_samples", 16'(want.wide), 16'(out_wide_samples));
        check_field("stereo_mode", 16'(want.stereo), 16'(out_stereo_mode));
        check_field("signed_mode", 16'(want.signed_md), 16'(out_signed_mode));
        check_field("auto_repeat", 16'(want.auto_rep), 16'(out_auto_repeat));
        check_field("block_count", want.count, out_block_count);
      end
    end
  end

  // result side pacing, with a long hold-off every so often to back up the input
  initial begin : result_pacing
    int unsigned n, since_hold;
    bit          calm;
    since_hold = 0;
    calm = 1'b0;
    @(posedge clk);
    forever begin
      if (since_hold >= 700) begin
        since_hold = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0) calm = ($urandom_range(0, 3) == 0);
        n = pick_gap(calm);
        if (n != 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        since_hold += n + 1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    access_t     a;
    dir_row_t    row;
    logic [15:0] v;
    int unsigned sent, offered;
    bit          calm;

    // power-on state of the predictor
    ver_word = VERSION_RST;
    dsp_latch = 1'b0;
    mix_idx = 8'h00;
    for (int i = 0; i < MIX_REGS; i++) mix_mem[i] = 8'h00;
    restart_dsp();
    reply_q.delete();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset version word
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_stim(i);
      a.cmd = row.cmd;
      a.port = row.port;
      a.data = row.data;
      send_access(a, pick_gap(1'b0), row.typed, row.rd);
    end

    // random phases, one version word each
    offered = 0;
    calm = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: v = 16'hFFFF;
        1: v = 16'h0000;
        2: v = 16'($urandom_range(0, 65535));
        default: v = VERSION_RST;
      endcase
      write_version(v);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if (offered % 48 == 0) calm = ($urandom_range(0, 3) == 0);
        if (stim_q.size() == 0) plan_sequence();
        a = stim_q.pop_front();
        send_access(a, pick_gap(calm), 1'b0, 8'h00);
        offered++;
        if (a.cmd != CMD_NONE) sent++;
      end
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!fault_seen) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #24_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
